>>> rtl/led_panel_framebuffer_scan_unit_assert.svh
// Assertion macros for the LED panel framebuffer scan unit.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef LED_PANEL_FRAMEBUFFER_SCAN_UNIT_ASSERT_SVH
`define LED_PANEL_FRAMEBUFFER_SCAN_UNIT_ASSERT_SVH
`ifndef SYNTH
// Property check, disabled while reset is asserted.
`define LPFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// A condition that must never be true.
`define LPFS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LPFS_ASSERT(lbl, prop, msg)
`define LPFS_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/lpfs_pkg.sv
// Shared constants, codes and types of the LED panel framebuffer scan unit.
// Used by every module of the block; depends on nothing.
package lpfs_pkg;

  // Panel geometry and framebuffer size.
  localparam int MAX_PANELS   = 4;
  localparam int PANEL_WIDTH  = 32;
  localparam int PANEL_HEIGHT = 16;
  localparam int RAM_DEPTH    = 256;
  localparam int ROW_BYTES    = PANEL_WIDTH / 8;
  localparam int GROUP_STEP   = PANEL_HEIGHT / 4;
  localparam int PANEL_BYTES  = ROW_BYTES * PANEL_HEIGHT;

  localparam int ADDR_W = $clog2(RAM_DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int TOT_W  = $clog2(MAX_PANELS + 1);
  localparam int I_W    = $clog2(MAX_PANELS * ROW_BYTES);

  // Fill patterns (active low pixels).
  localparam logic [7:0] FILL_OFF = 8'hFF;
  localparam logic [7:0] FILL_ON  = 8'h00;

  // Register reset values.
  localparam int RST_PANELS   = 1;
  localparam int BRIGHT_FULL  = 255;
  localparam int RST_ROW_TIME = 100;

  typedef enum logic [1:0] {
    CFG_PANELS_WIDE = 2'd0,
    CFG_PANELS_HIGH = 2'd1,
    CFG_BRIGHTNESS  = 2'd2,
    CFG_ROW_TIME    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SCAN  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_INVERSE = 3'd1,
    MODE_TOGGLE  = 3'd2,
    MODE_OR      = 3'd3,
    MODE_NOR     = 3'd4
  } mode_e;

  // Display geometry derived from the registers.
  typedef struct packed {
    logic [2:0]       panels_wide;
    logic [2:0]       panels_high;
    logic [TOT_W-1:0] total;
    logic             geo_ok;
  } geom_t;

  // Framebuffer memory access for one cycle.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
  } ram_req_t;

  // Tag that travels with a scan read.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [1:0] grp;
  } rd_tag_t;

endpackage

>>> rtl/lpfs_ram.sv
// Framebuffer memory: one write port, one read port, registered read data.
// Depends on lpfs_pkg for the request type and depth.
module lpfs_ram (
  input  logic                clk_i,
  input  lpfs_pkg::ram_req_t  req_i,
  output logic [7:0]          rdata_o
);
  import lpfs_pkg::*;

  logic [7:0] mem [RAM_DEPTH];
  logic [7:0] rdata_q;

  // Synchronous write and read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lpfs_cfg.sv
// Configuration registers, geometry check and output-enable timing.
// Depends on lpfs_pkg for register codes, reset values and the geometry type.
module lpfs_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [9:0]          cfg_wdata_i,
  output lpfs_pkg::geom_t     geom_o,
  output logic [9:0]          on_time_o,
  output logic [9:0]          off_time_o
);
  import lpfs_pkg::*;

  logic [2:0]  pw_q, ph_q;
  logic [7:0]  bright_q;
  logic [9:0]  rtime_q;
  logic [17:0] prod_q, prod_d;
  logic [9:0]  on_q, off_q, on_d, off_d;
  logic [5:0]  tot;
  logic [9:0]  q0;
  logic [10:0] r1;
  logic [2:0]  a1;
  logic [8:0]  r2;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q     <= 3'(RST_PANELS);
      ph_q     <= 3'(RST_PANELS);
      bright_q <= 8'(BRIGHT_FULL);
      rtime_q  <= 10'(RST_ROW_TIME);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PANELS_WIDE: pw_q     <= cfg_wdata_i[2:0];
        CFG_PANELS_HIGH: ph_q     <= cfg_wdata_i[2:0];
        CFG_BRIGHTNESS:  bright_q <= cfg_wdata_i[7:0];
        CFG_ROW_TIME:    rtime_q  <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // Panel count and its validity.
  always_comb begin
    tot                = 6'(pw_q) * 6'(ph_q);
    geom_o.panels_wide = pw_q;
    geom_o.panels_high = ph_q;
    geom_o.total       = tot[TOT_W-1:0];
    geom_o.geo_ok      = (tot != 6'd0) && (tot <= 6'(MAX_PANELS));
  end

  // On time is row_time * brightness / 255. The product is split as
  // 256*q0 + lo, so the remainder lo + q0 is folded once more and then
  // needs a single compare and subtract.
  always_comb begin
    prod_d = 18'(rtime_q) * 18'(bright_q);
    q0     = prod_q[17:8];
    r1     = 11'(prod_q[7:0]) + 11'(q0);
    a1     = r1[10:8];
    r2     = 9'(r1[7:0]) + 9'(a1);
    on_d   = q0 + 10'(a1) + 10'(r2 >= 9'(BRIGHT_FULL));
    off_d  = rtime_q - on_d;
  end

  // Timing pipeline; user changes registers only when block idle; unenforced.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    on_q   <= on_d;
    off_q  <= off_d;
  end

  assign on_time_o  = on_q;
  assign off_time_o = off_q;

endmodule

>>> rtl/lpfs_outq.sv
// Two-entry result queue behind the framebuffer read port, with credit for
// reads in flight. Depends on lpfs_pkg for the read tag type.
module lpfs_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpfs_pkg::rd_tag_t   tag_i,
  input  logic [7:0]          rdata_i,
  input  logic [9:0]          on_i,
  input  logic [9:0]          off_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          data_byte_o,
  output logic [1:0]          row_group_o,
  output logic [9:0]          on_time_o,
  output logic [9:0]          off_time_o,
  output logic                last_o
);
  import lpfs_pkg::*;

  rd_tag_t    infl_q;
  logic [7:0] data_q [2];
  logic       last_q [2];
  logic [1:0] grp_q  [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  logic [2:0] occ;

  // Occupancy including the read in flight; a pop this cycle frees a slot.
  always_comb begin
    push    = infl_q.valid;
    pop     = out_valid_o && out_ready_i;
    occ     = 3'(cnt_q) + 3'(infl_q.valid) - 3'(pop);
    space_o = occ < 3'd2;
    cnt_d   = cnt_q + 2'(push) - 2'(pop);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      infl_q <= tag_i;
      cnt_q  <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue entries.
  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= rdata_i;
      last_q[wr_ptr_q] <= infl_q.last;
      grp_q[wr_ptr_q]  <= infl_q.grp;
    end
  end

  // Head of the queue; group and times are shown on the final byte only.
  always_comb begin
    out_valid_o = cnt_q != 2'd0;
    data_byte_o = data_q[rd_ptr_q];
    last_o      = last_q[rd_ptr_q];
    row_group_o = last_o ? grp_q[rd_ptr_q] : 2'd0;
    on_time_o   = last_o ? on_i : 10'd0;
    off_time_o  = last_o ? off_i : 10'd0;
  end

endmodule

>>> rtl/lpfs_ctrl.sv
// Request sequencer: pixel read-modify-write, fill sweeps and scan reads.
// Depends on lpfs_pkg for codes, geometry, memory request and tag types.
module lpfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          x_i,
  input  logic [6:0]          y_i,
  input  logic [2:0]          mode_i,
  input  logic                pixel_i,
  input  logic                clear_to_off_i,
  input  logic                bus_free_i,
  input  lpfs_pkg::geom_t     geom_i,
  input  logic [7:0]          rdata_i,
  input  logic                space_i,
  output lpfs_pkg::ram_req_t  ram_req_o,
  output lpfs_pkg::rd_tag_t   tag_o
);
  import lpfs_pkg::*;

  localparam int SUM_W = ADDR_W + 4;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, clr_end_q, clr_end_d;
  logic [7:0]        fill_q, fill_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]        mask_q, mask_d;
  logic [2:0]        mode_q, mode_d;
  logic              pix_q, pix_d;
  logic [I_W-1:0]    i_q, i_d, i_end_q, i_end_d;
  logic [1:0]        k_q, k_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [TOT_W-1:0]  tot_q, tot_d;
  logic [1:0]        scan_row_q, scan_row_d;

  logic              accept, in_range, scan_last;
  logic [6:0]        panel;
  logic [SUM_W-1:0]  row_sum, wr_sum, scan_sum;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_mask;
  logic [TOT_W+1:0]  grp_off;

  // New byte value for one pixel write.
  function automatic logic [7:0] apply_mode(input logic [7:0] cur, input logic [7:0] mask,
                                            input logic [2:0] mode, input logic pix);
    logic [7:0] res;
    res = cur;
    case (mode)
      MODE_NORMAL:  res = pix ? (cur & ~mask) : (cur | mask);
      MODE_INVERSE: res = pix ? (cur | mask) : (cur & ~mask);
      MODE_TOGGLE:  res = pix ? (cur ^ mask) : cur;
      MODE_OR:      res = pix ? (cur & ~mask) : cur;
      MODE_NOR:     res = pix ? (cur | mask) : cur;
      default:      res = cur;
    endcase
    return res;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Pixel position to byte address and bit mask.
  always_comb begin
    in_range = (x_i < {geom_i.panels_wide, 5'b0}) && (y_i < {geom_i.panels_high, 4'b0});
    panel    = 7'(x_i[7:5]) + 7'(6'(geom_i.panels_wide) * 6'(y_i[6:4]));
    row_sum  = SUM_W'(y_i[3:0]) * SUM_W'(geom_i.total) * SUM_W'(ROW_BYTES);
    wr_sum   = SUM_W'(panel) * SUM_W'(ROW_BYTES) + SUM_W'(x_i[4:3]) + row_sum;
    wr_addr  = wr_sum[ADDR_W-1:0];
    wr_mask  = 8'h80 >> x_i[2:0];
  end

  // Scan address: row r + 4*(3-k) of byte column i.
  always_comb begin
    grp_off  = (TOT_W+2)'(tot_q) * (TOT_W+2)'(2'd3 - k_q);
    scan_sum = SUM_W'(base_q) + SUM_W'(i_q)
             + SUM_W'(grp_off) * SUM_W'(ROW_BYTES * GROUP_STEP);
    scan_last = (i_q == i_end_q) && (k_q == 2'd3);
  end

  // Next state and memory requests.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clr_end_d  = clr_end_q;
    fill_d     = fill_q;
    wr_addr_d  = wr_addr_q;
    mask_d     = mask_q;
    mode_d     = mode_q;
    pix_d      = pix_q;
    i_d        = i_q;
    i_end_d    = i_end_q;
    k_d        = k_q;
    base_d     = base_q;
    tot_d      = tot_q;
    scan_row_d = scan_row_q;
    ram_req_o  = '0;
    tag_o      = '0;

    unique case (state_q)
      ST_FILL: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cnt_q[ADDR_W-1:0];
        ram_req_o.wdata = fill_q;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == clr_end_q - 1'b1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && geom_i.geo_ok) begin
          case (op_i)
            OP_WRITE: begin
              if (in_range) begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = wr_addr;
                wr_addr_d       = wr_addr;
                mask_d          = wr_mask;
                mode_d          = mode_i;
                pix_d           = pixel_i;
                state_d         = ST_MODIFY;
              end
            end
            OP_CLEAR: begin
              cnt_d     = '0;
              clr_end_d = CNT_W'(SUM_W'(geom_i.total) * SUM_W'(PANEL_BYTES));
              fill_d    = clear_to_off_i ? FILL_OFF : FILL_ON;
              state_d   = ST_FILL;
            end
            OP_SCAN: begin
              if (bus_free_i) begin
                i_d     = '0;
                k_d     = 2'd0;
                tot_d   = geom_i.total;
                i_end_d = I_W'(SUM_W'(geom_i.total) * SUM_W'(ROW_BYTES) - 1'b1);
                base_d  = ADDR_W'(SUM_W'(geom_i.total) * SUM_W'(scan_row_q)
                                  * SUM_W'(ROW_BYTES));
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MODIFY: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = wr_addr_q;
        ram_req_o.wdata = apply_mode(rdata_i, mask_q, mode_q, pix_q);
        state_d         = ST_IDLE;
      end
      ST_SCAN: begin
        if (space_i) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = scan_sum[ADDR_W-1:0];
          tag_o.valid     = 1'b1;
          tag_o.last      = scan_last;
          tag_o.grp       = scan_row_q;
          if (k_q == 2'd3) begin
            k_d = 2'd0;
            if (i_q == i_end_q) begin
              scan_row_d = scan_row_q + 1'b1;
              state_d    = ST_IDLE;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered request context. Reset starts a fill sweep that
  // sets every framebuffer byte to dark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      cnt_q      <= '0;
      clr_end_q  <= CNT_W'(RAM_DEPTH);
      fill_q     <= FILL_OFF;
      scan_row_q <= 2'd0;
      wr_addr_q  <= '0;
      mask_q     <= '0;
      mode_q     <= '0;
      pix_q      <= 1'b0;
      i_q        <= '0;
      i_end_q    <= '0;
      k_q        <= 2'd0;
      base_q     <= '0;
      tot_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      clr_end_q  <= clr_end_d;
      fill_q     <= fill_d;
      scan_row_q <= scan_row_d;
      wr_addr_q  <= wr_addr_d;
      mask_q     <= mask_d;
      mode_q     <= mode_d;
      pix_q      <= pix_d;
      i_q        <= i_d;
      i_end_q    <= i_end_d;
      k_q        <= k_d;
      base_q     <= base_d;
      tot_q      <= tot_d;
    end
  end

endmodule

>>> rtl/led_panel_framebuffer_scan_unit.sv
// Top level of the LED panel framebuffer scan unit.
// Depends on lpfs_pkg, lpfs_cfg, lpfs_ram, lpfs_ctrl, lpfs_outq and the assert header.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    op, x, y, mode, pixel, clear_to_off,
//                                                   bus_free
//   out       output     out_valid_o / out_ready_i  data_byte, row_group, on_time,
//                                                   off_time, last
//   cfg       input      cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// A pixel write is one framebuffer read, then one write back.
// A clear writes 64 * panels bytes after the accepting cycle, one byte per cycle.
// A scan issues 16 * panels reads, one per cycle while the result queue has room.
// After reset a sweep sets all 256 framebuffer bytes dark; in_ready_o stays low.
// Items are taken one at a time; a stalled output holds at most two bytes.
`include "led_panel_framebuffer_scan_unit_assert.svh"

module led_panel_framebuffer_scan_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [9:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] x_i,
  input  logic [6:0] y_i,
  input  logic [2:0] mode_i,
  input  logic       pixel_i,
  input  logic       clear_to_off_i,
  input  logic       bus_free_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [1:0] row_group_o,
  output logic [9:0] on_time_o,
  output logic [9:0] off_time_o,
  output logic       last_o
);
  import lpfs_pkg::*;

  geom_t      geom;
  ram_req_t   ram_req;
  rd_tag_t    tag;
  logic [7:0] rdata;
  logic [9:0] on_time, off_time;
  logic       space;

  // Registers and timing.
  lpfs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .geom_o     (geom),
    .on_time_o  (on_time),
    .off_time_o (off_time)
  );

  // Request sequencer.
  lpfs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .x_i           (x_i),
    .y_i           (y_i),
    .mode_i        (mode_i),
    .pixel_i       (pixel_i),
    .clear_to_off_i(clear_to_off_i),
    .bus_free_i    (bus_free_i),
    .geom_i        (geom),
    .rdata_i       (rdata),
    .space_i       (space),
    .ram_req_o     (ram_req),
    .tag_o         (tag)
  );

  // Framebuffer.
  lpfs_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(rdata)
  );

  // Result queue.
  lpfs_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (tag),
    .rdata_i    (rdata),
    .on_i       (on_time),
    .off_i      (off_time),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_byte_o(data_byte_o),
    .row_group_o(row_group_o),
    .on_time_o  (on_time_o),
    .off_time_o (off_time_o),
    .last_o     (last_o)
  );

  // Group and times are zero on every byte but the final one of a scan.
  `LPFS_ASSERT(a_meta_only_last, out_valid_o && !last_o |-> row_group_o == 2'd0 && on_time_o == 10'd0 && off_time_o == 10'd0, "scan metadata on a non-final byte")
  // The memory is never read and written at the same address in one cycle.
  `LPFS_NEVER(a_no_rw_same, ram_req.we && ram_req.re && ram_req.waddr == ram_req.raddr, "framebuffer read and write collide")
  // A scan that starts blocks the input channel while it issues reads.
  `LPFS_ASSERT(a_scan_busy, in_valid_i && in_ready_o && op_i == OP_SCAN && bus_free_i && geom.geo_ok |=> !in_ready_o, "input taken during a scan")

endmodule

>>> tb/led_panel_framebuffer_scan_unit_tb.sv
// Self-checking testbench for the LED panel framebuffer scan unit.
// Depends on lpfs_pkg and the led_panel_framebuffer_scan_unit RTL; a shadow framebuffer
// predicts every scanned byte, which is checked in order against the output channel.
module led_panel_framebuffer_scan_unit_tb;
  import lpfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Longest quiet stretch of the block: a full clear or the reset sweep, plus margin.
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned IDLE_PCT      = 37;
  localparam int unsigned REPORT_MAX    = 10;
  localparam logic [1:0]  OP_NONE       = 2'd3;
  localparam logic [2:0]  MODE_UNUSED   = 3'd6;

  // One byte of scan output, with the row select and times on the final byte.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] grp;
    logic [9:0] on_t;
    logic [9:0] off_t;
    logic       last;
  } panel_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [9:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] op_i;
  logic [7:0] x_i;
  logic [6:0] y_i;
  logic [2:0] mode_i;
  logic       pixel_i;
  logic       clear_to_off_i;
  logic       bus_free_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] data_byte_o;
  logic [1:0] row_group_o;
  logic [9:0] on_time_o;
  logic [9:0] off_time_o;
  logic       last_o;

  // Shadow copy of the block's state and registers.
  logic [7:0]  shadow_fb [RAM_DEPTH];
  logic [1:0]  shadow_row;
  int unsigned sh_wide;
  int unsigned sh_high;
  int unsigned sh_bright;
  int unsigned sh_row_time;

  panel_byte_t queued_bytes [$];

  logic        allow_idle = 1'b1;
  int unsigned hold_left  = 0;
  int unsigned cycles     = 0;
  int unsigned failures   = 0;
  int unsigned items_sent = 0;
  int unsigned scans_run  = 0;
  int unsigned bytes_checked = 0;
  int unsigned stall_cycles  = 0;

  always #10 clk_i = ~clk_i;

  led_panel_framebuffer_scan_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .x_i            (x_i),
    .y_i            (y_i),
    .mode_i         (mode_i),
    .pixel_i        (pixel_i),
    .clear_to_off_i (clear_to_off_i),
    .bus_free_i     (bus_free_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .row_group_o    (row_group_o),
    .on_time_o      (on_time_o),
    .off_time_o     (off_time_o),
    .last_o         (last_o)
  );

  // Number of tiled panels, or 0 when the geometry is not usable.
  function automatic int unsigned shadow_panels();
    int unsigned t;
    t = sh_wide * sh_high;
    return (t == 0 || t > MAX_PANELS) ? 0 : t;
  endfunction

  // Apply one accepted request to the shadow state and queue the bytes a scan produces.
  function automatic void apply_request(logic [1:0] op, logic [7:0] x, logic [6:0] y,
                                        logic [2:0] mode, logic pix, logic cto, logic bus);
    int unsigned tot, panel, col, addr, rowsize, base, on_t, i, k;
    logic [7:0]  mask, cur;
    panel_byte_t b;
    tot = shadow_panels();
    if (tot == 0) return;
    case (op)
      OP_WRITE: begin
        if (x < PANEL_WIDTH * sh_wide && y < PANEL_HEIGHT * sh_high) begin
          panel = x / PANEL_WIDTH + sh_wide * (y / PANEL_HEIGHT);
          col   = x % PANEL_WIDTH + panel * PANEL_WIDTH;
          addr  = (col / 8 + (y % PANEL_HEIGHT) * tot * ROW_BYTES) % RAM_DEPTH;
          mask  = 8'h80 >> (col % 8);
          cur   = shadow_fb[addr];
          // Bit value 0 is a lit pixel.
          case (mode)
            MODE_NORMAL:  cur = pix ? (cur & ~mask) : (cur | mask);
            MODE_INVERSE: cur = pix ? (cur | mask) : (cur & ~mask);
            MODE_TOGGLE:  if (pix) cur = cur ^ mask;
            MODE_OR:      if (pix) cur = cur & ~mask;
            MODE_NOR:     if (pix && (cur & mask) == 8'h00) cur = cur | mask;
            default: ;
          endcase
          shadow_fb[addr] = cur;
        end
      end
      OP_CLEAR: begin
        for (addr = 0; addr < tot * PANEL_BYTES; addr++) begin
          shadow_fb[addr] = cto ? FILL_OFF : FILL_ON;
        end
      end
      OP_SCAN: begin
        if (bus) begin
          rowsize = tot * ROW_BYTES;
          base    = rowsize * shadow_row;
          // Rows r+12, r+8, r+4 and r for each byte column.
          for (i = 0; i < rowsize; i++) begin
            for (k = 0; k < 4; k++) begin
              b      = '0;
              b.data = shadow_fb[(base + i + rowsize * GROUP_STEP * (3 - k)) % RAM_DEPTH];
              if (i == rowsize - 1 && k == 3) begin
                on_t    = sh_row_time * sh_bright / BRIGHT_FULL;
                b.grp   = shadow_row;
                b.on_t  = 10'(on_t);
                b.off_t = 10'(sh_row_time - on_t);
                b.last  = 1'b1;
              end
              queued_bytes.push_back(b);
            end
          end
          shadow_row = shadow_row + 2'd1;
          scans_run++;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic note_failure(string what);
    failures++;
    if (failures <= REPORT_MAX) $display("ERROR at cycle %0d: %s", cycles, what);
  endtask

  // Output side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= !(allow_idle && $urandom_range(99, 0) < IDLE_PCT);
    end
  end

  // Check every accepted output byte against the oldest queued prediction.
  always @(posedge clk_i) begin
    panel_byte_t want;
    if (rst_ni && in_valid_i && !in_ready_o) stall_cycles++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (queued_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h (last %0b)", data_byte_o, last_o));
      end else begin
        want = queued_bytes.pop_front();
        bytes_checked++;
        if (data_byte_o !== want.data || row_group_o !== want.grp ||
            on_time_o !== want.on_t || off_time_o !== want.off_t || last_o !== want.last) begin
          note_failure($sformatf(
            "expected data %02h grp %0d on %0d off %0d last %0b, got %02h %0d %0d %0d %0b",
            want.data, want.grp, want.on_t, want.off_t, want.last,
            data_byte_o, row_group_o, on_time_o, off_time_o, last_o));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes still due", cycles,
               queued_bytes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one request, hold it until it is taken, then predict its effect.
  task automatic send_item(logic [1:0] op, logic [7:0] x, logic [6:0] y, logic [2:0] mode,
                           logic pix, logic cto, logic bus);
    int unsigned gap;
    gap = (allow_idle && $urandom_range(99, 0) < IDLE_PCT) ? $urandom_range(6, 1) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    op_i           <= op;
    x_i            <= x;
    y_i            <= y;
    mode_i         <= mode;
    pixel_i        <= pix;
    clear_to_off_i <= cto;
    bus_free_i     <= bus;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_request(op, x, y, mode, pix, cto, bus);
    items_sent++;
  endtask

  // Drop valid, wait for every predicted byte, then let a clear run out.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (queued_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [9:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_PANELS_WIDE: sh_wide     = val[2:0];
      CFG_PANELS_HIGH: sh_high     = val[2:0];
      CFG_BRIGHTNESS:  sh_bright   = val[7:0];
      CFG_ROW_TIME:    sh_row_time = val[9:0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned wide, int unsigned high, int unsigned bright,
                           int unsigned rt);
    settle();
    write_reg(CFG_PANELS_WIDE, 10'(wide));
    write_reg(CFG_PANELS_HIGH, 10'(high));
    write_reg(CFG_BRIGHTNESS, 10'(bright));
    write_reg(CFG_ROW_TIME, 10'(rt));
  endtask

  // Mostly in-range writes and bus-free scans, with some noise mixed in.
  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  op;
    logic [7:0]  x;
    logic [6:0]  y;
    logic [2:0]  mode;
    pick = $urandom_range(99, 0);
    x    = 8'($urandom);
    y    = 7'($urandom);
    mode = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
    if (pick < 50) begin
      op = OP_WRITE;
      if ($urandom_range(4, 0) != 0) begin
        x = 8'($urandom_range(PANEL_WIDTH * sh_wide - 1, 0));
        y = 7'($urandom_range(PANEL_HEIGHT * sh_high - 1, 0));
      end
    end else if (pick < 60) begin
      op = OP_CLEAR;
    end else if (pick < 96) begin
      op = OP_SCAN;
    end else begin
      op = OP_NONE;
    end
    send_item(op, x, y, mode, 1'($urandom), 1'($urandom), $urandom_range(6, 0) != 0);
  endtask

  // Scans straight out of reset show a dark frame and the reset register values.
  task automatic test_reset_state();
    send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b1);
    send_item(OP_SCAN, 8'hFF, 7'h7F, MODE_NOR, 1'b1, 1'b1, 1'b1);
  endtask

  // Every write mode, dropped writes, busy bus, unknown op, both clears, group wrap.
  task automatic test_directed_ops();
    configure(1, 1, BRIGHT_FULL, 1023);
    send_item(OP_CLEAR, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd0, 7'd0, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd31, 7'd15, MODE_INVERSE, 1'b1, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd7, 7'd1, MODE_TOGGLE, 1'b1, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd7, 7'd1, MODE_TOGGLE, 1'b0, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd16, 7'd2, MODE_NOR, 1'b1, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd16, 7'd2, MODE_NOR, 1'b1, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd5, 7'd0, MODE_UNUSED, 1'b1, 1'b0, 1'b0);
    // Writes just past the display edge and at the field maximum are dropped.
    send_item(OP_WRITE, 8'd32, 7'd0, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd0, 7'd16, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd255, 7'd127, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
    send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
    send_item(OP_NONE, 8'h00, 7'h00, MODE_NORMAL, 1'b1, 1'b1, 1'b1);
    send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b1);
    send_item(OP_CLEAR, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'd1, 7'd0, MODE_OR, 1'b1, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd2, 7'd0, MODE_OR, 1'b0, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd3, 7'd0, MODE_INVERSE, 1'b0, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd4, 7'd0, MODE_NORMAL, 1'b1, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd24, 7'd12, MODE_NORMAL, 1'b1, 1'b0, 1'b0);
    repeat (4) send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b1);
  endtask

  // Each multi-panel tiling shape with brightness and row-time extremes.
  task automatic test_geometries();
    int unsigned shapes [7][4] = '{
      '{2, 1, 0, 1023}, '{1, 2, 255, 1}, '{4, 1, 128, 0}, '{1, 4, 1, 1000},
      '{2, 2, 254, 777}, '{3, 1, 100, 300}, '{1, 3, 37, 2}};
    foreach (shapes[s]) begin
      configure(shapes[s][0], shapes[s][1], shapes[s][2], shapes[s][3]);
      repeat (10) send_random_item();
      send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b1);
    end
  endtask

  // Unusable geometry: everything is ignored and the row group holds.
  task automatic test_bad_geometry();
    logic [9:0] shapes [4][2] = '{'{10'h3F8, 10'h001}, '{10'h005, 10'h001},
                                  '{10'h002, 10'h003}, '{10'h3FF, 10'h3FF}};
    foreach (shapes[s]) begin
      settle();
      write_reg(CFG_PANELS_WIDE, shapes[s][0]);
      write_reg(CFG_PANELS_HIGH, shapes[s][1]);
      send_item(OP_WRITE, 8'd3, 7'd3, MODE_NORMAL, 1'b1, 1'b0, 1'b0);
      send_item(OP_CLEAR, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b0);
      send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b1);
    end
    configure(4, 1, 200, 640);
    send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b1);
  endtask

  // Hold the output off long enough that the block stops taking requests.
  task automatic test_output_stall();
    configure(2, 2, 200, 500);
    allow_idle = 1'b0;
    hold_left  = 600;
    repeat (4) send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b1);
    send_item(OP_WRITE, 8'd40, 7'd20, MODE_NORMAL, 1'b1, 1'b0, 1'b0);
    send_item(OP_SCAN, 8'h00, 7'h00, MODE_NORMAL, 1'b0, 1'b0, 1'b1);
    allow_idle = 1'b1;
  endtask

  // Random traffic over random usable settings; one phase runs without idling.
  task automatic test_random_traffic();
    int unsigned wide, high, bright, rt, sel;
    for (int unsigned phase = 0; phase < 5; phase++) begin
      wide   = $urandom_range(MAX_PANELS, 1);
      high   = $urandom_range(MAX_PANELS / wide, 1);
      sel    = $urandom_range(4, 0);
      bright = (sel == 0) ? 0 : (sel == 1) ? BRIGHT_FULL : $urandom_range(254, 1);
      sel    = $urandom_range(9, 0);
      rt     = (sel == 0) ? 0 : (sel == 1) ? 1023 : $urandom_range(1023, 1);
      configure(wide, high, bright, rt);
      allow_idle = (phase != 1);
      repeat (56) send_random_item();
    end
    allow_idle = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_PANELS_WIDE;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    op_i           = OP_WRITE;
    x_i            = '0;
    y_i            = '0;
    mode_i         = MODE_NORMAL;
    pixel_i        = 1'b0;
    clear_to_off_i = 1'b0;
    bus_free_i     = 1'b0;
    out_ready_i    = 1'b0;
    foreach (shadow_fb[a]) shadow_fb[a] = FILL_OFF;
    shadow_row  = 2'd0;
    sh_wide     = RST_PANELS;
    sh_high     = RST_PANELS;
    sh_bright   = BRIGHT_FULL;
    sh_row_time = RST_ROW_TIME;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_directed_ops();
    test_geometries();
    test_bad_geometry();
    test_output_stall();
    test_random_traffic();
    settle();

    $display("Covered %0d requests, %0d scans and %0d checked bytes over several tilings,",
             items_sent, scans_run, bytes_checked);
    $display("with %0d cycles of input stall and %0d mismatches.", stall_cycles, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lpfs_pkg.sv
rtl/lpfs_ram.sv
rtl/lpfs_cfg.sv
rtl/lpfs_outq.sv
rtl/lpfs_ctrl.sv
rtl/led_panel_framebuffer_scan_unit.sv
tb/led_panel_framebuffer_scan_unit_tb.sv
